[rtl/bss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

	localparam int unsigned MAX_HEADER_BYTES_DEF = 1024;
	localparam int unsigned MIN_PIXEL_OFFSET     = 14;

	localparam logic [7:0] MAGIC_B = 8'h42;
	localparam logic [7:0] MAGIC_M = 8'h4D;

	// Configuration register indexes.
	localparam logic REG_EXP_WIDTH  = 1'b0;
	localparam logic REG_EXP_HEIGHT = 1'b1;

	// Byte positions inside the file header.
	localparam int unsigned POS_MAGIC_B  = 0;
	localparam int unsigned POS_MAGIC_M  = 1;
	localparam int unsigned POS_FSIZE    = 2;
	localparam int unsigned POS_OFFSET   = 10;
	localparam int unsigned POS_OFF_LAST = 13;
	localparam int unsigned POS_WIDTH    = 18;
	localparam int unsigned POS_HEIGHT   = 22;
	localparam int unsigned FIELD_BYTES  = 4;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_BAD_OFF   = 3'd2,
		ST_DIM       = 3'd3,
		ST_SIZE      = 3'd4,
		ST_OVERRUN   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_BODY   = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [31:0] file_size;
		logic [31:0] pixel_offset;
		logic [31:0] width;
		logic [31:0] height;
	} hdr_fields_t;

endpackage

`default_nettype wire

[rtl/bss_fields.sv]
`timescale 1ns / 1ps
`default_nettype none

module bss_fields
	import bss_pkg::*;
#(
	parameter int unsigned POS_W = $clog2(MAX_HEADER_BYTES_DEF)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             capture,
	input  wire logic             clear,
	input  wire logic [POS_W-1:0] pos,
	input  wire logic [7:0]       data,
	output hdr_fields_t           fields_nxt
);

	hdr_fields_t fields_q;

	function automatic logic [31:0] put_lane(input logic [31:0] acc, input logic [7:0] b,
		input logic [1:0] lane);
		logic [31:0] r;
		r = acc;
		r[8*lane +: 8] = b;
		return r;
	endfunction

	function automatic logic in_field(input logic [POS_W-1:0] p, input int unsigned base);
		return (p >= POS_W'(base)) && (p <= POS_W'(base + FIELD_BYTES - 1));
	endfunction

	function automatic logic [1:0] lane_of(input logic [POS_W-1:0] p, input int unsigned base);
		logic [1:0] b2;
		b2 = 2'(base);
		return 2'(p[1:0] - b2);
	endfunction

	// The merged view includes the byte of the current transfer, so the verdict
	// on the last header byte sees the complete field values.
	always_comb begin
		fields_nxt = fields_q;
		if (in_field(pos, POS_FSIZE)) begin
			fields_nxt.file_size = put_lane(fields_q.file_size, data, lane_of(pos, POS_FSIZE));
		end else if (in_field(pos, POS_OFFSET)) begin
			fields_nxt.pixel_offset = put_lane(fields_q.pixel_offset, data,
				lane_of(pos, POS_OFFSET));
		end else if (in_field(pos, POS_WIDTH)) begin
			fields_nxt.width = put_lane(fields_q.width, data, lane_of(pos, POS_WIDTH));
		end else if (in_field(pos, POS_HEIGHT)) begin
			fields_nxt.height = put_lane(fields_q.height, data, lane_of(pos, POS_HEIGHT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_q <= '0;
		end else if (clear) begin
			fields_q <= '0;
		end else if (capture) begin
			fields_q <= fields_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/bmp_stream_splitter_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   data_byte
// result    out        out_valid / out_stall out_byte, image_index, in_header,
//                                            header_accepted, end_of_image, status
// config    in         cfg_we                cfg_index, cfg_data
//
// One byte is accepted per cycle while the result side does not stall; its result passes
// through the input register and is then presented from the result register.
// The input register and the result register are the only stages; a stalled full
// result register holds the input register, which then stalls the input side.
// The asynchronous reset clears all control state and the header fields at once.
// A stall on the result side propagates back to in_stall within the same cycle.

module bmp_stream_splitter_top
	import bss_pkg::*;
#(
	parameter int unsigned MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             image_index,
	output logic             in_header,
	output logic             header_accepted,
	output logic             end_of_image,
	output logic [2:0]       status,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned POS_W = $clog2(MAX_HEADER_BYTES);

	logic        s1_valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        fire;
	logic        in_take;

	logic [15:0] exp_width_q;
	logic [15:0] exp_height_q;

	phase_t             phase_q;
	logic               cur_image_q;
	logic [POS_W-1:0]   hpos_q;
	logic [31:0]        body_left_q;
	status_t            err_q;
	logic               magic_bad_q;

	hdr_fields_t fields_nxt;
	logic        capture;
	logic        clear;

	logic        hdr_c;
	logic        acc_c;
	logic        eoi_c;
	status_t     st_c;
	status_t     err_c;
	logic        done_c;
	logic        magic_bad_c;
	logic [31:0] abs_h;
	logic        finish_c;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        image_index_q;
	logic        in_header_q;
	logic        header_accepted_q;
	logic        end_of_image_q;
	status_t     status_q;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = s1_valid_s1 && advance;
	assign in_stall = s1_valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign capture = fire && (err_q == ST_OK) && (phase_q == PH_HEADER);
	assign clear   = fire && finish_c && !cur_image_q;

	bss_fields #(
		.POS_W(POS_W)
	) u_fields (
		.clk       (clk),
		.arst_n    (arst_n),
		.capture   (capture),
		.clear     (clear),
		.pos       (hpos_q),
		.data      (byte_s1),
		.fields_nxt(fields_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_width_q  <= '0;
			exp_height_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_EXP_HEIGHT) begin
				exp_height_q <= cfg_data;
			end else begin
				exp_width_q <= cfg_data;
			end
		end
	end

	always_comb begin
		hdr_c       = 1'b0;
		acc_c       = 1'b0;
		eoi_c       = 1'b0;
		st_c        = ST_OK;
		err_c       = ST_OK;
		done_c      = 1'b0;
		finish_c    = 1'b0;
		magic_bad_c = magic_bad_q;
		abs_h       = fields_nxt.height[31] ? (32'd0 - fields_nxt.height) : fields_nxt.height;

		if (err_q != ST_OK) begin
			st_c = err_q;
		end else begin
			case (phase_q)
				PH_DONE: begin
					err_c = ST_OVERRUN;
				end
				PH_HEADER: begin
					hdr_c = 1'b1;
					if (hpos_q == POS_W'(POS_MAGIC_B) && byte_s1 != MAGIC_B) begin
						magic_bad_c = 1'b1;
					end else if (hpos_q == POS_W'(POS_MAGIC_M) && byte_s1 != MAGIC_M) begin
						magic_bad_c = 1'b1;
					end

					if (hpos_q == POS_W'(POS_OFF_LAST)) begin
						if (magic_bad_q) begin
							err_c = ST_BAD_MAGIC;
						end else if (fields_nxt.pixel_offset < 32'(MIN_PIXEL_OFFSET) ||
							fields_nxt.pixel_offset > 32'(MAX_HEADER_BYTES)) begin
							err_c = ST_BAD_OFF;
						end else if (fields_nxt.pixel_offset == 32'(MIN_PIXEL_OFFSET)) begin
							done_c = 1'b1;
						end
					end else if (hpos_q > POS_W'(POS_OFF_LAST) &&
						32'(hpos_q) + 32'd1 == fields_nxt.pixel_offset) begin
						done_c = 1'b1;
					end

					if (done_c) begin
						if (exp_width_q != '0 && exp_height_q != '0 &&
							(fields_nxt.width != {16'd0, exp_width_q} ||
							abs_h != {16'd0, exp_height_q})) begin
							err_c = ST_DIM;
						end else if (fields_nxt.file_size < fields_nxt.pixel_offset) begin
							err_c = ST_SIZE;
						end
					end

					if (err_c == ST_OK && done_c) begin
						acc_c = 1'b1;
						if (fields_nxt.file_size == fields_nxt.pixel_offset) begin
							eoi_c    = 1'b1;
							finish_c = 1'b1;
						end
					end
				end
				PH_BODY: begin
					if (body_left_q == '0) begin
						eoi_c    = 1'b1;
						finish_c = 1'b1;
					end
				end
				default: begin
					err_c = ST_OK;
				end
			endcase
			st_c = err_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			cur_image_q <= 1'b0;
			hpos_q      <= '0;
			body_left_q <= '0;
			err_q       <= ST_OK;
			magic_bad_q <= 1'b0;
		end else if (fire && err_q == ST_OK) begin
			magic_bad_q <= magic_bad_c;
			if (err_c != ST_OK) begin
				err_q <= err_c;
			end else if (finish_c) begin
				if (!cur_image_q) begin
					cur_image_q <= 1'b1;
					phase_q     <= PH_HEADER;
					hpos_q      <= '0;
					magic_bad_q <= 1'b0;
				end else begin
					phase_q <= PH_DONE;
				end
			end else if (phase_q == PH_HEADER) begin
				if (done_c) begin
					phase_q     <= PH_BODY;
					body_left_q <= fields_nxt.file_size - fields_nxt.pixel_offset - 32'd1;
				end else begin
					hpos_q <= hpos_q + POS_W'(1);
				end
			end else if (phase_q == PH_BODY) begin
				body_left_q <= body_left_q - 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				s1_valid_s1 <= 1'b1;
			end else if (fire) begin
				s1_valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
		end
		if (fire) begin
			out_byte_q        <= byte_s1;
			image_index_q     <= cur_image_q;
			in_header_q       <= hdr_c;
			header_accepted_q <= acc_c;
			end_of_image_q    <= eoi_c;
			status_q          <= st_c;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign image_index     = image_index_q;
	assign in_header       = in_header_q;
	assign header_accepted = header_accepted_q;
	assign end_of_image    = end_of_image_q;
	assign status          = status_q;

	// An error, once recorded, never changes until reset.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) |=> (err_q == $past(err_q)))
		else $error("recorded error changed");

	// An accepted header is always reported inside the header with a clean status.
	a_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && header_accepted_q) |-> (in_header_q && status_q == ST_OK))
		else $error("header accepted with bad status");

	// End of image is only marked on a clean byte.
	a_eoi_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_of_image_q) |-> (status_q == ST_OK))
		else $error("end of image with error status");

	// An empty input register never stalls the input side.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_s1 |-> !in_stall)
		else $error("input stalled while input register empty");

	// After the second image the block has left the first one.
	a_done_second: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> cur_image_q)
		else $error("done phase reached on the first image");

endmodule

`default_nettype wire
